// ===== sv/psu_pkg.sv =====
// Package for the PNG scanline unfilter: payload structs, register indexes,
// filter type codes and default sizes. No dependencies.
package psu_pkg;

    localparam int MAX_ROW_BYTES_DEF   = 8192;
    localparam int MAX_PIXEL_BYTES_DEF = 8;

    localparam int ROW_BYTES_W = 14;
    localparam int BPP_W       = 4;
    localparam int CFG_DATA_W  = ROW_BYTES_W;
    localparam int RECENT_W    = 3;

    localparam logic REG_ROW_BYTES = 1'b0;
    localparam logic REG_BPP       = 1'b1;

    localparam logic [7:0] FILT_NONE  = 8'd0;
    localparam logic [7:0] FILT_SUB   = 8'd1;
    localparam logic [7:0] FILT_UP    = 8'd2;
    localparam logic [7:0] FILT_AVG   = 8'd3;
    localparam logic [7:0] FILT_PAETH = 8'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       image_start;
    } psu_in_t;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       row_end;
    } psu_out_t;

endpackage

// ===== sv/png_scanline_unfilter.sv =====
// PNG scanline filter reconstruction (None, Sub, Up, Average, Paeth), one byte per cycle
// while the output is not stalled. Depends on psu_pkg.
//
// channel  dir  handshake          payload
// s_       in   s_valid/s_ready    psu_in_t  {data_byte, image_start}
// m_       out  m_valid/m_ready    psu_out_t {pixel_byte, row_end}
// cfg_     in   cfg_wr_en          cfg_addr selects row_bytes or bytes_per_pixel
//
// Throughput is one byte per cycle while the output is free; a byte taken into the input
// register is reconstructed into the result register once the output is free.
// The prior-row RAM is read ahead at the next row position into a registered output; a
// one-entry bypass covers a write and read of the same entry.
// No clearing pass after reset: prior-row RAM data is only used after being written.
// A stalled result holds its input byte; filter type bytes retire without a result.
module png_scanline_unfilter #(
    parameter int MAX_ROW_BYTES   = psu_pkg::MAX_ROW_BYTES_DEF,
    parameter int MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  psu_pkg::psu_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output psu_pkg::psu_out_t                   m_data,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_addr,
    input  logic [psu_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import psu_pkg::*;

    localparam int PW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int LW = $clog2(MAX_ROW_BYTES + 1);
    localparam int KW = (LW > ROW_BYTES_W) ? LW : ROW_BYTES_W;
    localparam int AW = (PW > BPP_W) ? PW : BPP_W;

    logic [ROW_BYTES_W-1:0] row_bytes_reg;
    logic [BPP_W-1:0]       bpp_reg;

    logic                   in_valid_reg;
    psu_in_t                in_data_reg;
    logic                   out_valid_reg;
    psu_out_t               out_data_reg;

    logic [PW-1:0]          pos_reg, pos_next;
    logic [7:0]             kind_reg;
    logic                   awaiting_reg, first_row_reg;

    logic [7:0]             mem [0:MAX_ROW_BYTES-1];
    logic [7:0]             rdata_reg;
    logic                   hit_reg;
    logic [7:0]             byp_reg;
    logic [PW-1:0]          rd_addr;

    logic [7:0]             cur_recent [0:7];
    logic [7:0]             pri_recent [0:7];

    logic                   awaiting_eff, first_row_eff;
    logic                   out_free, fire, fire_data, last;
    logic [KW-1:0]          rb_eff, pos_inc;
    logic [BPP_W-1:0]       bpp_eff;
    logic [AW-1:0]          pos_ext, back_ext;
    logic [RECENT_W-1:0]    back_idx;
    logic [7:0]             x, a, b, c, r, paeth;
    logic [8:0]             avg_sum;
    logic signed [9:0]      da, db, dc;
    logic [9:0]             pa, pb, pc;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_bytes_reg <= ROW_BYTES_W'(1);
            bpp_reg       <= BPP_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_ROW_BYTES: row_bytes_reg <= cfg_wdata;
                REG_BPP:       bpp_reg       <= cfg_wdata[BPP_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        if (row_bytes_reg == '0)
            rb_eff = KW'(1);
        else if (KW'(row_bytes_reg) > KW'(MAX_ROW_BYTES))
            rb_eff = KW'(MAX_ROW_BYTES);
        else
            rb_eff = KW'(row_bytes_reg);

        if (bpp_reg == '0)
            bpp_eff = BPP_W'(1);
        else if (bpp_reg > BPP_W'(MAX_PIXEL_BYTES))
            bpp_eff = BPP_W'(MAX_PIXEL_BYTES);
        else
            bpp_eff = bpp_reg;
    end

    // handshake
    assign awaiting_eff  = in_data_reg.image_start | awaiting_reg;
    assign first_row_eff = in_data_reg.image_start | first_row_reg;
    assign out_free      = !out_valid_reg || m_ready;
    assign fire          = in_valid_reg && (awaiting_eff || out_free);
    assign fire_data     = fire && !awaiting_eff;
    assign s_ready       = !in_valid_reg || fire;
    assign m_valid       = out_valid_reg;
    assign m_data        = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            in_valid_reg <= 1'b0;
        else if (s_ready)
            in_valid_reg <= s_valid;
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid)
            in_data_reg <= s_data;
    end

    // reconstruction
    always_comb begin
        x        = in_data_reg.data_byte;
        pos_ext  = AW'(pos_reg);
        back_ext = pos_ext - AW'(bpp_eff);
        back_idx = back_ext[RECENT_W-1:0];
        pos_inc  = KW'(pos_reg) + KW'(1);
        last     = pos_inc >= rb_eff;

        b = first_row_reg ? 8'd0 : (hit_reg ? byp_reg : rdata_reg);
        if (pos_ext >= AW'(bpp_eff)) begin
            a = cur_recent[back_idx];
            c = first_row_reg ? 8'd0 : pri_recent[back_idx];
        end else begin
            a = 8'd0;
            c = 8'd0;
        end

        da = 10'(signed'({2'b00, b})) - 10'(signed'({2'b00, c}));
        db = 10'(signed'({2'b00, a})) - 10'(signed'({2'b00, c}));
        dc = 10'(signed'({2'b00, a})) + 10'(signed'({2'b00, b}))
           - 10'(signed'({1'b0, c, 1'b0}));
        pa = da[9] ? 10'(-da) : 10'(da);
        pb = db[9] ? 10'(-db) : 10'(db);
        pc = dc[9] ? 10'(-dc) : 10'(dc);
        if (pa <= pb && pa <= pc)
            paeth = a;
        else if (pb <= pc)
            paeth = b;
        else
            paeth = c;

        avg_sum = {1'b0, a} + {1'b0, b};

        case (kind_reg)
            FILT_SUB:   r = x + a;
            FILT_UP:    r = x + b;
            FILT_AVG:   r = x + avg_sum[8:1];
            FILT_PAETH: r = x + paeth;
            default:    r = x;
        endcase

        if (awaiting_eff || last)
            pos_next = '0;
        else
            pos_next = PW'(pos_inc);
        rd_addr = fire ? pos_next : pos_reg;
    end

    // row state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            kind_reg      <= FILT_NONE;
            awaiting_reg  <= 1'b1;
            first_row_reg <= 1'b1;
            hit_reg       <= 1'b0;
        end else begin
            hit_reg <= fire_data && (pos_reg == rd_addr);
            if (fire) begin
                pos_reg <= pos_next;
                if (awaiting_eff) begin
                    kind_reg      <= x;
                    awaiting_reg  <= 1'b0;
                    first_row_reg <= first_row_eff;
                end else if (last) begin
                    awaiting_reg  <= 1'b1;
                    first_row_reg <= 1'b0;
                end
            end
        end
    end

    // prior-row RAM, recent-byte windows, bypass
    always_ff @(posedge aclk) begin
        if (fire_data)
            mem[pos_reg] <= r;
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        byp_reg <= r;
        if (fire_data) begin
            cur_recent[pos_ext[RECENT_W-1:0]] <= r;
            pri_recent[pos_ext[RECENT_W-1:0]] <= b;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn)
            out_valid_reg <= 1'b0;
        else if (fire_data)
            out_valid_reg <= 1'b1;
        else if (m_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (fire_data) begin
            out_data_reg.pixel_byte <= r;
            out_data_reg.row_end    <= last;
        end
    end

`ifndef SYNTHESIS
    a_row_end_rearms: assert property (@(posedge aclk) disable iff (!aresetn)
        fire_data && last |=> awaiting_reg && !first_row_reg)
        else $error("row end did not rearm filter byte");

    a_bypass_at_row_start: assert property (@(posedge aclk) disable iff (!aresetn)
        hit_reg |-> pos_reg == '0)
        else $error("RAM bypass hit away from row start");

    a_result_in_order: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> !$past(fire_data))
        else $error("result overwritten while stalled");
`endif

endmodule
